// ===== rtl/bbc_pkg.sv =====
// Shared constants, types and the character classifier for the bracket balance checker.
`default_nettype none

package bbc_pkg;

    // Default number of entries on the bracket stack.
    localparam int unsigned DEFAULT_STACK_DEPTH = 64;

    // Stream widths: input data is one text byte, output data is two flags padded to a byte.
    localparam int unsigned IN_TDATA_W  = 8;
    localparam int unsigned OUT_TDATA_W = 8;
    localparam int unsigned RESULT_W    = 2;

    // Width of one stored bracket kind.
    localparam int unsigned KIND_W = 2;

    typedef logic [KIND_W-1:0] t_kind;

    // Bracket kinds as stored on the stack.
    localparam t_kind KIND_ROUND  = 2'd0;
    localparam t_kind KIND_SQUARE = 2'd1;
    localparam t_kind KIND_ANGLE  = 2'd2;
    localparam t_kind KIND_CURLY  = 2'd3;

    // Character codes of the eight brackets.
    localparam logic [7:0] CHAR_ROUND_OPEN   = 8'h28;
    localparam logic [7:0] CHAR_ROUND_CLOSE  = 8'h29;
    localparam logic [7:0] CHAR_SQUARE_OPEN  = 8'h5B;
    localparam logic [7:0] CHAR_SQUARE_CLOSE = 8'h5D;
    localparam logic [7:0] CHAR_ANGLE_OPEN   = 8'h3C;
    localparam logic [7:0] CHAR_ANGLE_CLOSE  = 8'h3E;
    localparam logic [7:0] CHAR_CURLY_OPEN   = 8'h7B;
    localparam logic [7:0] CHAR_CURLY_CLOSE  = 8'h7D;

    typedef struct packed {
        logic  opener;
        logic  closer;
        t_kind kind;
    } t_cls;

    function automatic t_cls classify(input logic [7:0] b);
        t_cls c;
        c = '{opener: 1'b0, closer: 1'b0, kind: KIND_ROUND};
        case (b)
            CHAR_ROUND_OPEN:   begin c.opener = 1'b1; c.kind = KIND_ROUND;  end
            CHAR_SQUARE_OPEN:  begin c.opener = 1'b1; c.kind = KIND_SQUARE; end
            CHAR_ANGLE_OPEN:   begin c.opener = 1'b1; c.kind = KIND_ANGLE;  end
            CHAR_CURLY_OPEN:   begin c.opener = 1'b1; c.kind = KIND_CURLY;  end
            CHAR_ROUND_CLOSE:  begin c.closer = 1'b1; c.kind = KIND_ROUND;  end
            CHAR_SQUARE_CLOSE: begin c.closer = 1'b1; c.kind = KIND_SQUARE; end
            CHAR_ANGLE_CLOSE:  begin c.closer = 1'b1; c.kind = KIND_ANGLE;  end
            CHAR_CURLY_CLOSE:  begin c.closer = 1'b1; c.kind = KIND_CURLY;  end
            default:           c.opener = 1'b0;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/bbc_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
`default_nettype none

module bbc_ram #(
    parameter int unsigned WIDTH = 2,
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/bracket_balance_checker.sv =====
// Top level of the bracket balance checker: stack pointer stage, compare stage and result slots.
// A result is formed from the compare stage registers and registered in a result slot for output.
// Throughput: one byte per cycle; the input is held back only while two results wait on a
// stalled receiver and a final byte is ready to leave the compare stage.
// Reset: i_rst_n is synchronous and active low; it empties the stack and clears the flags.
// The stack memory is not cleared, as only entries below the stack level are ever read.
`default_nettype none

module bracket_balance_checker #(
    parameter int unsigned STACK_DEPTH = bbc_pkg::DEFAULT_STACK_DEPTH
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // Input stream.
    input  wire logic                            i_s_tvalid,
    output logic                                 o_s_tready,
    input  wire logic [bbc_pkg::IN_TDATA_W-1:0]  i_s_tdata,   // [7:0] text_byte
    input  wire logic                            i_s_tlast,   // final_byte
    // Result stream.
    output logic                                 o_m_tvalid,
    input  wire logic                            i_m_tready,
    output logic      [bbc_pkg::OUT_TDATA_W-1:0] o_m_tdata    // [0] balanced, [1] nesting_overflow
);

    import bbc_pkg::*;

    localparam int unsigned LVL_W  = $clog2(STACK_DEPTH + 1);
    localparam int unsigned ADDR_W = $clog2(STACK_DEPTH);
    localparam logic [LVL_W-1:0] LVL_FULL = LVL_W'(STACK_DEPTH);
    localparam logic [LVL_W-1:0] LVL_ONE  = LVL_W'(1);

    // The stack lives in a RAM. All address arithmetic is done in the first stage, from
    // the stack level alone, so pushes write and pops issue their read as the byte is
    // accepted. A pop that follows a push to the same entry reads it after the write has
    // landed, so no forwarding is needed. The popped kind comes back from the registered
    // read port and is compared in the second stage, which also keeps the sticky mismatch flag.

    // ---------------------------------------------------------------- first stage
    logic             accept;
    t_cls             cls;
    logic             push;
    logic             pop;
    logic             empty_close;
    logic             ovf_hit;
    logic [LVL_W-1:0] lvl_after;
    logic [LVL_W-1:0] r_level, n_level;
    logic             r_ovf, n_ovf;

    assign accept = i_s_tvalid && o_s_tready;
    assign cls    = classify(i_s_tdata);

    always_comb begin
        push        = accept && cls.opener && (r_level < LVL_FULL);
        ovf_hit     = accept && cls.opener && (r_level >= LVL_FULL);
        pop         = accept && cls.closer && (r_level != '0);
        empty_close = accept && cls.closer && (r_level == '0);
        lvl_after   = r_level;
        if (push) begin
            lvl_after = r_level + LVL_ONE;
        end else if (pop) begin
            lvl_after = r_level - LVL_ONE;
        end
        n_level = r_level;
        n_ovf   = r_ovf;
        if (accept) begin
            // A final byte finishes the text, so the next text starts with an empty stack.
            n_level = i_s_tlast ? '0 : lvl_after;
            n_ovf   = i_s_tlast ? 1'b0 : (r_ovf || ovf_hit);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_level <= n_level;
            r_ovf   <= n_ovf;
        end
    end

    // ---------------------------------------------------------------- stack memory
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic [LVL_W-1:0]  lvl_below;
    t_kind             top_kind;

    assign lvl_below = r_level - LVL_ONE;
    assign wr_addr   = r_level[ADDR_W-1:0];
    assign rd_addr   = lvl_below[ADDR_W-1:0];

    // The read is only enabled by a pop, so the read data holds while the compare stage
    // is held back behind the waiting results.
    bbc_ram #(
        .WIDTH (KIND_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (push),
        .i_waddr (wr_addr),
        .i_wdata (cls.kind),
        .i_re    (pop),
        .i_raddr (rd_addr),
        .o_rdata (top_kind)
    );

    // ---------------------------------------------------------------- compare stage
    logic  r_s2_valid;
    logic  r_s2_final;
    logic  r_s2_pop;
    logic  r_s2_empty_close;
    logic  r_s2_empty;
    logic  r_s2_ovf;
    t_kind r_s2_kind;
    logic  r_mm, n_mm;
    logic  s2_fire;
    logic  mm_now;
    logic  mm_total;

    // Two result slots: the head drives the output, and the second slot catches a result
    // that arrives while the head is still waiting, so one stall does not stop the text.
    logic  r_out_valid, n_out_valid;
    logic  r_out_bal, n_out_bal;
    logic  r_out_ovf, n_out_ovf;
    logic  r_skid_valid, n_skid_valid;
    logic  r_skid_bal, n_skid_bal;
    logic  r_skid_ovf, n_skid_ovf;

    // A final item may only leave the compare stage while the second result slot is free.
    assign s2_fire  = r_s2_valid && !(r_s2_final && r_skid_valid);
    assign mm_now   = r_s2_empty_close || (r_s2_pop && (top_kind != r_s2_kind));
    assign mm_total = r_mm || mm_now;

    always_comb begin
        n_mm = r_mm;
        if (s2_fire) begin
            n_mm = r_s2_final ? 1'b0 : mm_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_mm       <= 1'b0;
        end else begin
            r_mm <= n_mm;
            if (accept) begin
                r_s2_valid <= 1'b1;
            end else if (s2_fire) begin
                r_s2_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s2_final       <= i_s_tlast;
            r_s2_pop         <= pop;
            r_s2_empty_close <= empty_close;
            r_s2_empty       <= (lvl_after == '0);
            r_s2_ovf         <= r_ovf || ovf_hit;
            r_s2_kind        <= cls.kind;
        end
    end

    // ---------------------------------------------------------------- result slots
    logic load_out;
    logic res_bal;

    assign load_out = s2_fire && r_s2_final;
    assign res_bal  = !mm_total && !r_s2_ovf && r_s2_empty;

    // The head refills from the second slot first, so results leave in order.
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_bal    = r_out_bal;
        n_out_ovf    = r_out_ovf;
        n_skid_valid = r_skid_valid;
        n_skid_bal   = r_skid_bal;
        n_skid_ovf   = r_skid_ovf;
        if (!r_out_valid || i_m_tready) begin
            if (r_skid_valid) begin
                n_out_valid  = 1'b1;
                n_out_bal    = r_skid_bal;
                n_out_ovf    = r_skid_ovf;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = load_out;
                n_out_bal   = res_bal;
                n_out_ovf   = r_s2_ovf;
            end
        end else if (load_out) begin
            n_skid_valid = 1'b1;
            n_skid_bal   = res_bal;
            n_skid_ovf   = r_s2_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_bal  <= n_out_bal;
        r_out_ovf  <= n_out_ovf;
        r_skid_bal <= n_skid_bal;
        r_skid_ovf <= n_skid_ovf;
    end

    // Input is refused only while a final item is held in the compare stage behind two
    // waiting results; the condition is taken from registers alone.
    assign o_s_tready = !(r_s2_valid && r_s2_final && r_skid_valid);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {(OUT_TDATA_W - RESULT_W)'(0), r_out_ovf, r_out_bal};

`ifndef SYNTH
    a_level_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level <= LVL_FULL)
        else $error("stack level above depth");

    a_final_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_s_tlast |=> (r_level == '0) && !r_ovf)
        else $error("state not cleared after final byte");

    a_result_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(o_m_tdata[0] && o_m_tdata[1]))
        else $error("balanced reported together with overflow");

    a_no_lost_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |-> !r_skid_valid)
        else $error("result overwrites a waiting result");
`endif

endmodule

`default_nettype wire
